[hdl/matrix_row_operation_engine_macros.svh]
// Assertion shorthands for the row operation engine.
`ifndef MATRIX_ROW_OPERATION_ENGINE_MACROS_SVH
`define MATRIX_ROW_OPERATION_ENGINE_MACROS_SVH

// Same-cycle implication, held off while reset is low
`define MROE_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("row engine check failed");

// Next-cycle implication, held off while reset is low
`define MROE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("row engine check failed");

`endif

[hdl/mroe_pkg.sv]
package mroe_pkg;

    // Field and bus widths
    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int IDX_W       = 4;
    localparam int CFG_W       = 5;
    localparam int FRAC_W      = 16;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int MAX_DIM_DEF = 16;

    // Size register reset values
    localparam logic [CFG_W-1:0] ROWS_RST = 5'd10;
    localparam logic [CFG_W-1:0] COLS_RST = 5'd10;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [2*DATA_W-1:0] FRAC_BIAS = (64'sd1 <<< FRAC_W) - 64'sd1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 3'd0,
        OP_SWAP  = 3'd1,
        OP_SCALE = 3'd2,
        OP_ADD   = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    typedef enum logic [0:0] {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_RUN,
        ST_RESULT
    } t_state;

    // Q16.16 product to integer: truncate toward zero, saturate to 32 bits
    function automatic logic signed [DATA_W-1:0] f_scale(
        input logic signed [2*DATA_W-1:0] prod
    );
        logic signed [2*DATA_W-1:0] biased;
        logic [2*DATA_W-FRAC_W-1:0] quo;
        biased = prod + (prod[2*DATA_W-1] ? FRAC_BIAS : '0);
        quo    = biased[2*DATA_W-1:FRAC_W];
        if (quo[2*DATA_W-FRAC_W-1:DATA_W-1] !=
            {(DATA_W-FRAC_W+1){quo[2*DATA_W-FRAC_W-1]}}) begin
            return quo[2*DATA_W-FRAC_W-1] ? S32_MIN : S32_MAX;
        end
        return quo[DATA_W-1:0];
    endfunction

    // Saturating signed 32-bit add
    function automatic logic signed [DATA_W-1:0] f_sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic [DATA_W:0] sum;
        sum = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (sum[DATA_W] != sum[DATA_W-1]) begin
            return sum[DATA_W] ? S32_MIN : S32_MAX;
        end
        return sum[DATA_W-1:0];
    endfunction

endpackage

[hdl/mroe_in_if.sv]
interface mroe_in_if;
    logic                               valid;
    logic                               ready;
    logic [mroe_pkg::OP_W-1:0]          op;
    logic [mroe_pkg::IDX_W-1:0]         row_a;
    logic [mroe_pkg::IDX_W-1:0]         row_b;
    logic [mroe_pkg::IDX_W-1:0]         col;
    logic signed [mroe_pkg::DATA_W-1:0] value;
    logic signed [mroe_pkg::DATA_W-1:0] factor;

    modport source (output valid, op, row_a, row_b, col, value, factor, input ready);
    modport sink   (input valid, op, row_a, row_b, col, value, factor, output ready);
endinterface

[hdl/mroe_out_if.sv]
interface mroe_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [mroe_pkg::DATA_W-1:0] read_value;
    logic                               index_error;

    modport source (output valid, read_value, index_error, input ready);
    modport sink   (input valid, read_value, index_error, output ready);
endinterface

[hdl/matrix_row_operation_engine.sv]
// Row operation engine over a MAX_DIM x MAX_DIM matrix of signed 32-bit elements held in
// one single-port-read, single-port-write memory. One request is in work at a time; a new
// one is taken while the previous result still waits on the output register. An element
// write goes from execute to result, a read passes a read-wait state on the way, and an
// index error or unused opcode goes straight to result. A swap, scale or add-scaled-row
// walks the columns in a run state: each column needs two element reads through the one
// read port, and the multiply, truncate/saturate and add stages overlap with later columns.
// The memory has no reset and no clearing pass; elements are undefined until written.
`include "matrix_row_operation_engine_macros.svh"

module matrix_row_operation_engine #(
    parameter int MAX_DIM = mroe_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mroe_in_if.sink                       i_req,
    mroe_out_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mroe_pkg::PADDR_W-1:0]  paddr,
    input  logic [mroe_pkg::PDATA_W-1:0]  pwdata,
    output logic [mroe_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_DIM);
    localparam int CW    = $clog2(MAX_DIM + 1);
    localparam int DW    = mroe_pkg::DATA_W;

    // Configuration
    logic [mroe_pkg::CFG_W-1:0] r_rows;
    logic [mroe_pkg::CFG_W-1:0] r_cols;
    logic [CW-1:0]              nr;
    logic [CW-1:0]              nc;

    // Control
    mroe_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_nc;
    logic [CW-1:0]    r_col;
    logic             r_ph;
    logic             r_rd0_v;
    logic             r_rd1_v;
    logic             r_w_v;
    logic [IW-1:0]    r_rd_col;
    logic [IW-1:0]    r_w_col;
    logic             r_out_v;

    // Latched request
    logic [mroe_pkg::OP_W-1:0]  r_op;
    logic [mroe_pkg::IDX_W-1:0] r_ra;
    logic [mroe_pkg::IDX_W-1:0] r_rb;
    logic [mroe_pkg::IDX_W-1:0] r_cx;
    logic signed [DW-1:0]       r_value;
    logic signed [DW-1:0]       r_k;

    // Datapath
    logic signed [DW-1:0]   r_first;
    logic signed [DW-1:0]   r_second;
    logic signed [2*DW-1:0] r_prod;
    logic signed [DW-1:0]   r_scl;
    logic signed [DW-1:0]   r_res_val;
    logic                   r_res_err;
    logic signed [DW-1:0]   r_out_val;
    logic                   r_out_err;

    // Memory port and sequencing controls
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [DW-1:0]        mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [DW-1:0]        mem_rdata;
    logic signed [DW-1:0] rd_s;
    logic                 acc;
    logic                 issue;
    logic                 run_start;
    logic                 res_load;
    logic signed [DW-1:0] res_val_n;
    logic                 res_err_n;
    logic                 out_load;
    logic                 a_ok;
    logic                 b_ok;
    logic                 c_ok;
    logic                 cfg_wr;

    function automatic logic [AW-1:0] f_addr(input logic [AW-1:0] row,
                                             input logic [AW-1:0] c);
        return AW'(row * AW'(MAX_DIM)) + c;
    endfunction

    mroe_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_s = mem_rdata;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= mroe_pkg::ROWS_RST;
            r_cols <= mroe_pkg::COLS_RST;
        end else if (cfg_wr) begin
            unique case (mroe_pkg::t_reg_idx'(paddr[2])) 
                mroe_pkg::REG_ROWS: r_rows <= pwdata[mroe_pkg::CFG_W-1:0];
                mroe_pkg::REG_COLS: r_cols <= pwdata[mroe_pkg::CFG_W-1:0];
                default:            r_rows <= r_rows;
            endcase
        end
    end

    always_comb begin
        unique case (mroe_pkg::t_reg_idx'(paddr[2]))
            mroe_pkg::REG_ROWS: prdata = mroe_pkg::PDATA_W'(r_rows);
            mroe_pkg::REG_COLS: prdata = mroe_pkg::PDATA_W'(r_cols);
            default:            prdata = '0;
        endcase
    end

    // Clamp sizes to the array dimension and check indices
    assign nr   = (32'(r_rows) >= 32'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(r_rows);
    assign nc   = (32'(r_cols) >= 32'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(r_cols);
    assign a_ok = 32'(r_ra) < 32'(nr);
    assign b_ok = 32'(r_rb) < 32'(nr);
    assign c_ok = 32'(r_cx) < 32'(nc);

    assign acc   = i_req.valid && i_req.ready;
    assign issue = r_col < r_nc;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mroe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, memory access and result selection
    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = '0;
        run_start   = 1'b0;
        res_load    = 1'b0;
        res_val_n   = '0;
        res_err_n   = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            mroe_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_state = mroe_pkg::ST_EXEC;
                end
            end
            mroe_pkg::ST_EXEC: begin
                n_state  = mroe_pkg::ST_RESULT;
                res_load = 1'b1;
                unique case (r_op) inside
                    mroe_pkg::OP_WRITE: begin
                        if (a_ok && c_ok) begin
                            mem_we    = 1'b1;
                            mem_waddr = f_addr(AW'(r_ra), AW'(r_cx));
                            mem_wdata = r_value;
                        end else begin
                            res_err_n = 1'b1;
                        end
                    end
                    mroe_pkg::OP_READ: begin
                        if (a_ok && c_ok) begin
                            mem_raddr = f_addr(AW'(r_ra), AW'(r_cx));
                            res_load  = 1'b0;
                            n_state   = mroe_pkg::ST_RDWAIT;
                        end else begin
                            res_err_n = 1'b1;
                        end
                    end
                    mroe_pkg::OP_SWAP, mroe_pkg::OP_ADD: begin
                        if (a_ok && b_ok) begin
                            run_start = 1'b1;
                            res_load  = 1'b0;
                            n_state   = mroe_pkg::ST_RUN;
                        end else begin
                            res_err_n = 1'b1;
                        end
                    end
                    mroe_pkg::OP_SCALE: begin
                        if (a_ok) begin
                            run_start = 1'b1;
                            res_load  = 1'b0;
                            n_state   = mroe_pkg::ST_RUN;
                        end else begin
                            res_err_n = 1'b1;
                        end
                    end
                    default: begin
                        res_err_n = 1'b0;
                    end
                endcase
            end
            mroe_pkg::ST_RDWAIT: begin
                res_load  = 1'b1;
                res_val_n = rd_s;
                n_state   = mroe_pkg::ST_RESULT;
            end
            mroe_pkg::ST_RUN: begin
                // Even phase reads row b for add and row a otherwise; odd phase reads row b for swap, row a otherwise
                if (!r_ph) begin
                    mem_raddr = f_addr(AW'((r_op == mroe_pkg::OP_ADD) ? r_rb : r_ra),
                                       AW'(r_col));
                end else begin
                    mem_raddr = f_addr(AW'((r_op == mroe_pkg::OP_SWAP) ? r_rb : r_ra),
                                       AW'(r_col));
                end
                // Swap puts the second row into the first as it arrives
                if (r_rd1_v && (r_op == mroe_pkg::OP_SWAP)) begin
                    mem_we    = 1'b1;
                    mem_waddr = f_addr(AW'(r_ra), AW'(r_rd_col));
                    mem_wdata = mem_rdata;
                end
                // Write back the finished column
                if (r_w_v) begin
                    mem_we = 1'b1;
                    if (r_op == mroe_pkg::OP_SWAP) begin
                        mem_waddr = f_addr(AW'(r_rb), AW'(r_w_col));
                        mem_wdata = r_first;
                    end else if (r_op == mroe_pkg::OP_SCALE) begin
                        mem_waddr = f_addr(AW'(r_ra), AW'(r_w_col));
                        mem_wdata = r_scl;
                    end else begin
                        mem_waddr = f_addr(AW'(r_ra), AW'(r_w_col));
                        mem_wdata = mroe_pkg::f_sat_add(r_second, r_scl);
                    end
                end
                if (!issue && !r_rd0_v && !r_rd1_v && !r_w_v) begin
                    res_load = 1'b1;
                    n_state  = mroe_pkg::ST_RESULT;
                end
            end
            mroe_pkg::ST_RESULT: begin
                if (!r_out_v || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = mroe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mroe_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold the request fields
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op    <= i_req.op;
            r_ra    <= i_req.row_a;
            r_rb    <= i_req.row_b;
            r_cx    <= i_req.col;
            r_value <= i_req.value;
            r_k     <= i_req.factor;
        end
    end

    // Advance the column walk and its pipeline tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc    <= '0;
            r_col   <= '0;
            r_ph    <= 1'b0;
            r_rd0_v <= 1'b0;
            r_rd1_v <= 1'b0;
            r_w_v   <= 1'b0;
        end else begin
            r_rd0_v <= (r_state == mroe_pkg::ST_RUN) && issue && !r_ph;
            r_rd1_v <= (r_state == mroe_pkg::ST_RUN) && issue && r_ph;
            r_w_v   <= r_rd1_v;
            if (run_start) begin
                r_nc  <= nc;
                r_col <= '0;
                r_ph  <= 1'b0;
            end else if ((r_state == mroe_pkg::ST_RUN) && issue) begin
                r_ph <= !r_ph;
                if (r_ph) begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // Column datapath: multiply, then truncate and saturate
    always_ff @(posedge i_clk) begin
        if ((r_state == mroe_pkg::ST_RUN) && issue) begin
            r_rd_col <= IW'(r_col);
        end
        if (r_rd1_v) begin
            r_w_col  <= r_rd_col;
            r_second <= rd_s;
            r_scl    <= mroe_pkg::f_scale(r_prod);
        end
        if (r_rd0_v) begin
            r_first <= rd_s;
            r_prod  <= rd_s * r_k;
        end
        if (res_load) begin
            r_res_val <= res_val_n;
            r_res_err <= res_err_n;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_load) begin
            r_out_v <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_val <= r_res_val;
            r_out_err <= r_res_err;
        end
    end

    assign o_rsp.valid       = r_out_v;
    assign o_rsp.read_value  = r_out_val;
    assign o_rsp.index_error = r_out_err;

    // Checks
    `MROE_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, acc, r_state == mroe_pkg::ST_EXEC)
    `MROE_ASSERT_IMPL(a_one_write, i_clk, i_rst_n, r_w_v, !r_rd1_v)
    `MROE_ASSERT_IMPL(a_col_bound, i_clk, i_rst_n, r_state == mroe_pkg::ST_RUN, r_col <= r_nc)
    `MROE_ASSERT_IMPL(a_write_state, i_clk, i_rst_n, mem_we,
        r_state == mroe_pkg::ST_EXEC || r_state == mroe_pkg::ST_RUN)
    `MROE_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, r_out_v && r_out_err, r_out_val == '0)

endmodule

[hdl/mroe_ram.sv]
module mroe_ram #(
    parameter int WIDTH = mroe_pkg::DATA_W,
    parameter int DEPTH = mroe_pkg::MAX_DIM_DEF * mroe_pkg::MAX_DIM_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
